### hdl/sksw_pkg.sv
// ----------------------------------------------------------------------------
// sksw_pkg
// shared types and constants for the skyline sweep heap unit
// ----------------------------------------------------------------------------
package sksw_pkg;

    localparam int unsigned HEIGHT_BITS = 31;
    localparam int unsigned POS_BITS    = 31;

    localparam logic FUNC_ENTER = 1'b0;
    localparam logic FUNC_LEAVE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_MOVE_LAST,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_SIFT_WR,
        ST_TOP_RD,
        ST_TOP_CHK,
        ST_EMIT
    } state_t;

endpackage

### hdl/sksw_heap_mem.sv
// ----------------------------------------------------------------------------
// sksw_heap_mem
// heap storage: height and count per slot, one write and one read port
// ----------------------------------------------------------------------------
module sksw_heap_mem #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned COUNT_BITS = 16,
    parameter int unsigned ADDR_BITS  = 6
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [ADDR_BITS-1:0]               wr_addr,
    input  logic [sksw_pkg::HEIGHT_BITS-1:0]   wr_height,
    input  logic [COUNT_BITS-1:0]              wr_count,
    input  logic [ADDR_BITS-1:0]               rd_addr,
    output logic [sksw_pkg::HEIGHT_BITS-1:0]   rd_height,
    output logic [COUNT_BITS-1:0]              rd_count
);

    logic [sksw_pkg::HEIGHT_BITS-1:0] height_mem [DEPTH];
    logic [COUNT_BITS-1:0]            count_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            height_mem[wr_addr] <= wr_height;
            count_mem[wr_addr]  <= wr_count;
        end
        rd_height <= height_mem[rd_addr];
        rd_count  <= count_mem[rd_addr];
    end

endmodule

### hdl/skyline_sweep_counted_max_heap_unit.sv
// ----------------------------------------------------------------------------
// skyline_sweep_counted_max_heap_unit
// skyline key points from sorted edge events via a counted max-heap
// ----------------------------------------------------------------------------
// steps: a linear search over the live slots, then decide, then a sift up, or
//   a sift down after the last entry moves in, one level at a time, then the
//   top check and emit
// flow: one event at a time, taken only in idle after the last one is done;
//   the heap accesses share the single memory read port
// reset: the heap size register restarts at 1 and slot 0 is treated as the
//   seed (height 0, count 1) until first written; no clearing pass
// ----------------------------------------------------------------------------
module skyline_sweep_counted_max_heap_unit #(
    parameter int unsigned HEAP_DEPTH = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_pos[30:0], edge_height[61:31], zero pad
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // point_x[30:0], point_height[61:31], zero pad
    output logic        m_tuser    // overflow
);

    localparam int unsigned HB = sksw_pkg::HEIGHT_BITS;
    localparam int unsigned AB = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned SB = AB + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [SB-1:0] DEPTH_S = SB'(HEAP_DEPTH);

    sksw_pkg::state_t state_reg, state_next;

    logic          func_reg, func_next;
    logic [30:0]   x_reg, x_next;
    logic [HB-1:0] h_reg, h_next;
    logic [SB-1:0] size_reg, size_next;
    logic          seed_reg, seed_next;      // slot 0 still holds reset seed
    logic [SB-1:0] idx_reg, idx_next;        // search index / sift position
    logic          found_reg, found_next;
    logic [AB-1:0] slot_reg, slot_next;
    logic          taller_reg, taller_next;
    logic [HB-1:0] top_reg, top_next;
    logic          down_reg, down_next;      // sift direction
    logic [1:0]    rd_phase_reg, rd_phase_next;
    logic [HB-1:0] cur_h_reg, cur_h_next;
    logic [COUNT_BITS-1:0] cur_c_reg, cur_c_next;
    logic [HB-1:0] l_h_reg, l_h_next;
    logic [COUNT_BITS-1:0] l_c_reg, l_c_next;
    logic [HB-1:0] o_h_reg, o_h_next;        // other node (parent or best child)
    logic [COUNT_BITS-1:0] o_c_reg, o_c_next;
    logic [AB-1:0] o_idx_reg, o_idx_next;
    logic          ov_reg, ov_next;
    logic [30:0]   px_reg, px_next;
    logic [HB-1:0] ph_reg, ph_next;

    logic                  wr_en;
    logic [AB-1:0]         wr_addr, rd_addr;
    logic [HB-1:0]         wr_h, mem_h, rd_h;
    logic [COUNT_BITS-1:0] wr_c, mem_c, rd_c;
    logic                  rd_seed_reg;

    sksw_heap_mem #(
        .DEPTH(HEAP_DEPTH), .COUNT_BITS(COUNT_BITS), .ADDR_BITS(AB)
    ) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_height(wr_h),
        .wr_count(wr_c), .rd_addr(rd_addr), .rd_height(mem_h), .rd_count(mem_c)
    );

    // slot 0 reads as the seed until the first write after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_seed_reg <= 1'b0;
        else
            rd_seed_reg <= seed_reg && (rd_addr == '0) && !(wr_en && wr_addr == '0);
    end
    assign rd_h = rd_seed_reg ? '0 : mem_h;
    assign rd_c = rd_seed_reg ? COUNT_BITS'(1) : mem_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sksw_pkg::ST_IDLE;
            size_reg  <= SB'(1);
            seed_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            seed_reg  <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;     x_reg <= x_next;       h_reg <= h_next;
        idx_reg <= idx_next;       found_reg <= found_next;
        slot_reg <= slot_next;     taller_reg <= taller_next;
        top_reg <= top_next;       down_reg <= down_next;
        rd_phase_reg <= rd_phase_next;
        cur_h_reg <= cur_h_next;   cur_c_reg <= cur_c_next;
        l_h_reg <= l_h_next;       l_c_reg <= l_c_next;
        o_h_reg <= o_h_next;       o_c_reg <= o_c_next;   o_idx_reg <= o_idx_next;
        ov_reg <= ov_next;         px_reg <= px_next;     ph_reg <= ph_next;
    end

    // child index helpers (wide enough to test against size)
    logic [SB:0] lchild, rchild;
    assign lchild = {idx_reg, 1'b1};
    assign rchild = {idx_reg, 1'b0} + (SB+1)'(2);

    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg;  x_next = x_reg;  h_next = h_reg;
        size_next = size_reg;  seed_next = seed_reg;
        idx_next = idx_reg;    found_next = found_reg;  slot_next = slot_reg;
        taller_next = taller_reg;  top_next = top_reg;  down_next = down_reg;
        rd_phase_next = rd_phase_reg;
        cur_h_next = cur_h_reg;  cur_c_next = cur_c_reg;
        l_h_next = l_h_reg;  l_c_next = l_c_reg;
        o_h_next = o_h_reg;  o_c_next = o_c_reg;  o_idx_next = o_idx_reg;
        ov_next = ov_reg;  px_next = px_reg;  ph_next = ph_reg;
        wr_en = 1'b0;  wr_addr = '0;  wr_h = '0;  wr_c = '0;
        rd_addr = '0;

        case (state_reg)
            sksw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next = s_tuser;
                    x_next    = s_tdata[30:0];
                    h_next    = s_tdata[61:31];
                    idx_next  = '0;
                    found_next = 1'b0;
                    rd_phase_next = '0;
                    rd_addr = '0;                   // top read for taller test
                    state_next = sksw_pkg::ST_SEARCH;
                end
            end

            // one slot per cycle: next address issued while the current compares
            sksw_pkg::ST_SEARCH:
            begin
                if (rd_phase_reg == 2'd0)
                begin
                    top_next = (size_reg != '0) ? rd_h : '0;
                    rd_phase_next = 2'd1;
                    rd_addr = idx_reg[AB-1:0];
                    if (idx_reg >= size_reg)
                        state_next = sksw_pkg::ST_DECIDE;
                end
                else
                begin
                    if (rd_h == h_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = idx_reg[AB-1:0];
                        cur_c_next = rd_c;
                        state_next = sksw_pkg::ST_DECIDE;
                    end
                    else if (idx_reg + SB'(1) >= size_reg ||
                             idx_reg + SB'(1) >= DEPTH_S)
                        state_next = sksw_pkg::ST_DECIDE;
                    else
                    begin
                        idx_next = idx_reg + SB'(1);
                        rd_addr = AB'(idx_reg + SB'(1));
                    end
                end
            end

            sksw_pkg::ST_DECIDE:
            begin
                taller_next = h_reg > top_reg;
                ov_next = 1'b0;  px_next = x_reg;
                if (func_reg == sksw_pkg::FUNC_ENTER)
                begin
                    ph_next = h_reg;
                    if (found_reg)
                    begin
                        wr_en = 1'b1;  wr_addr = slot_reg;  wr_h = h_reg;
                        wr_c = (cur_c_reg < CMAX) ? cur_c_reg + 1'b1 : cur_c_reg;
                        if (slot_reg == '0) seed_next = 1'b0;
                        cur_h_next = h_reg;  cur_c_next = wr_c;
                        idx_next = {1'b0, slot_reg};
                        down_next = 1'b0;
                        rd_phase_next = '0;
                        state_next = sksw_pkg::ST_SIFT_RD;
                    end
                    else if (size_reg >= DEPTH_S)
                    begin
                        ov_next = 1'b1;  px_next = '0;  ph_next = '0;
                        state_next = sksw_pkg::ST_EMIT;
                    end
                    else
                    begin
                        wr_en = 1'b1;  wr_addr = size_reg[AB-1:0];
                        wr_h = h_reg;  wr_c = COUNT_BITS'(1);
                        if (size_reg == '0) seed_next = 1'b0;
                        cur_h_next = h_reg;  cur_c_next = COUNT_BITS'(1);
                        idx_next = size_reg;
                        size_next = size_reg + SB'(1);
                        down_next = 1'b0;
                        rd_phase_next = '0;
                        state_next = sksw_pkg::ST_SIFT_RD;
                    end
                end
                else if (!found_reg)
                    state_next = sksw_pkg::ST_IDLE;
                else if (cur_c_reg > COUNT_BITS'(1))
                begin
                    wr_en = 1'b1;  wr_addr = slot_reg;  wr_h = h_reg;
                    wr_c = cur_c_reg - 1'b1;
                    if (slot_reg == '0) seed_next = 1'b0;
                    rd_phase_next = '0;
                    state_next = sksw_pkg::ST_TOP_RD;
                end
                else
                begin
                    size_next = size_reg - SB'(1);
                    rd_addr = AB'(size_reg - SB'(1));
                    rd_phase_next = '0;
                    state_next = sksw_pkg::ST_MOVE_LAST;
                end
            end

            // replace the removed slot with the last entry
            sksw_pkg::ST_MOVE_LAST:
            begin
                if (rd_phase_reg == 2'd0)
                begin
                    rd_addr = size_reg[AB-1:0];     // last slot, size already dropped
                    rd_phase_next = 2'd1;
                end
                else
                begin
                    cur_h_next = rd_h;  cur_c_next = rd_c;
                    if ({1'b0, slot_reg} < size_reg)
                    begin
                        wr_en = 1'b1;  wr_addr = slot_reg;
                        wr_h = rd_h;  wr_c = rd_c;
                        if (slot_reg == '0) seed_next = 1'b0;
                        idx_next = {1'b0, slot_reg};
                        down_next = 1'b1;
                        rd_phase_next = '0;
                        state_next = sksw_pkg::ST_SIFT_RD;
                    end
                    else
                    begin
                        rd_phase_next = '0;
                        state_next = sksw_pkg::ST_TOP_RD;
                    end
                end
            end

            // fetch neighbor(s): parent for sift up, children for sift down
            sksw_pkg::ST_SIFT_RD:
            begin
                if (down_reg)
                begin
                    if (rd_phase_reg == 2'd0)
                    begin
                        if (lchild >= {1'b0, size_reg})
                        begin
                            down_next = 1'b0;
                            idx_next = {1'b0, slot_reg};
                        end
                        else
                        begin
                            rd_addr = lchild[AB-1:0];
                            rd_phase_next = 2'd1;
                        end
                    end
                    else if (rd_phase_reg == 2'd1)
                    begin
                        l_h_next = rd_h;  l_c_next = rd_c;
                        rd_addr = rchild[AB-1:0];
                        rd_phase_next = 2'd2;
                    end
                    else
                    begin
                        if (rchild < {1'b0, size_reg} && rd_h > l_h_reg)
                        begin
                            o_h_next = rd_h;  o_c_next = rd_c;
                            o_idx_next = rchild[AB-1:0];
                        end
                        else
                        begin
                            o_h_next = l_h_reg;  o_c_next = l_c_reg;
                            o_idx_next = lchild[AB-1:0];
                        end
                        state_next = sksw_pkg::ST_SIFT_CMP;
                    end
                end
                else
                begin
                    if (idx_reg == '0 || idx_reg >= DEPTH_S)
                    begin
                        rd_phase_next = '0;
                        state_next = sksw_pkg::ST_TOP_RD;
                    end
                    else if (rd_phase_reg == 2'd0)
                    begin
                        rd_addr = AB'((idx_reg - SB'(1)) >> 1);
                        o_idx_next = AB'((idx_reg - SB'(1)) >> 1);
                        rd_phase_next = 2'd1;
                    end
                    else
                    begin
                        o_h_next = rd_h;  o_c_next = rd_c;
                        state_next = sksw_pkg::ST_SIFT_CMP;
                    end
                end
            end

            // the shared compare: swap if the order is violated
            sksw_pkg::ST_SIFT_CMP:
            begin
                rd_phase_next = '0;
                if (down_reg ? (o_h_reg > cur_h_reg) : (cur_h_reg > o_h_reg))
                    state_next = sksw_pkg::ST_SIFT_WR;
                else if (down_reg)
                begin
                    down_next = 1'b0;
                    idx_next = {1'b0, slot_reg};
                    state_next = sksw_pkg::ST_SIFT_RD;
                end
                else
                    state_next = sksw_pkg::ST_TOP_RD;
            end

            // two writes: neighbor into current slot, then current into neighbor
            sksw_pkg::ST_SIFT_WR:
            begin
                if (rd_phase_reg == 2'd0)
                begin
                    wr_en = 1'b1;  wr_addr = idx_reg[AB-1:0];
                    wr_h = o_h_reg;  wr_c = o_c_reg;
                    if (idx_reg == '0) seed_next = 1'b0;
                    rd_phase_next = 2'd1;
                end
                else
                begin
                    wr_en = 1'b1;  wr_addr = o_idx_reg;
                    wr_h = cur_h_reg;  wr_c = cur_c_reg;
                    if (o_idx_reg == '0) seed_next = 1'b0;
                    idx_next = {1'b0, o_idx_reg};
                    if (down_reg) slot_next = o_idx_reg;
                    rd_phase_next = '0;
                    state_next = sksw_pkg::ST_SIFT_RD;
                end
            end

            sksw_pkg::ST_TOP_RD:
            begin
                rd_addr = '0;
                state_next = sksw_pkg::ST_TOP_CHK;
            end

            sksw_pkg::ST_TOP_CHK:
            begin
                if (func_reg == sksw_pkg::FUNC_ENTER)
                    state_next = taller_reg ? sksw_pkg::ST_EMIT : sksw_pkg::ST_IDLE;
                else
                begin
                    ph_next = (size_reg != '0) ? rd_h : '0;
                    state_next = (h_reg > ((size_reg != '0) ? rd_h : '0)) ?
                                 sksw_pkg::ST_EMIT : sksw_pkg::ST_IDLE;
                end
            end

            sksw_pkg::ST_EMIT:
            begin
                if (m_tready)
                    state_next = sksw_pkg::ST_IDLE;
            end

            default:
                state_next = sksw_pkg::ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == sksw_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sksw_pkg::ST_EMIT);
    assign m_tdata  = {2'b00, ph_reg, px_reg};
    assign m_tuser  = ov_reg;

endmodule
